### design/ptq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants
// Operation and status codes, register map and queue status flags for the
// two-class priority queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_QUEUED_HIGH = 3'd0,
    ST_QUEUED_LOW  = 3'd1,
    ST_REFUSED     = 3'd2,
    ST_SERVED_HIGH = 3'd3,
    ST_SERVED_LOW  = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  // Register index of the priority threshold.
  localparam logic CFG_IDX_THRESHOLD = 1'b0;

  localparam logic [7:0] THRESHOLD_RESET = 8'd60;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage : ptq_pkg
`default_nettype wire

### design/ptq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module ptq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule : ptq_ram
`default_nettype wire

### design/ptq_fifo_ptr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_fifo_ptr: circular queue pointer control
// Keeps head and count of one queue and derives the tail slot and the
// full and empty flags.
// ----------------------------------------------------------------------------
module ptq_fifo_ptr
  import ptq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic                       pop,
  output logic      [$clog2(DEPTH)-1:0]   head,
  output logic      [$clog2(DEPTH)-1:0]   tail,
  output logic      [$clog2(DEPTH+1)-1:0] count,
  output qstat_t                          stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW:0]   tail_sum;

  // head + count stays below twice the depth, so one subtract wraps it.
  assign tail_sum = (AW + 1)'(head_r) + (AW + 1)'(count_r);
  assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = head_r;
  assign count      = count_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule : ptq_fifo_ptr
`default_nettype wire

### design/two_class_priority_queue.sv
// Each accepted input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the result stream is not stalled; each touches
// one queue's pointers and one entry of that queue's RAM, whose registered read loads with the result register.
// Reset: rst_n (synchronous, active low) empties both queues and sets the
// threshold to 60; queue RAM contents are left as they are.
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_queue: two-level strict priority queue
// Enqueues identifiers into a high or low circular queue by class value and
// serves the high queue first, then the low queue.
// ----------------------------------------------------------------------------
module two_class_priority_queue
  import ptq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128,
  parameter int ID_WIDTH    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] item_id, [39:32] class_value
  input  wire logic        in_tuser,   // [0] operation
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] served_id
  output logic      [2:0]  out_tuser,  // [2:0] status
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration register.
  logic [7:0] threshold_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_THRESHOLD) ? {24'd0, threshold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == CFG_IDX_THRESHOLD) begin
      threshold_r <= cfg_pwdata[7:0];
    end
  end

  // Input register.
  logic                s1_valid_r;
  op_t                 s1_op_r;
  logic [ID_WIDTH-1:0] s1_id_r;
  logic [7:0]          s1_cls_r;

  // Result register.
  logic    s2_valid_r;
  status_t s2_status_r;

  logic    adv;
  logic    to_high;
  logic    push_hi, push_lo, pop_hi, pop_lo;
  status_t status_nxt;

  logic [AW-1:0]       hi_head, hi_tail, lo_head, lo_tail;
  logic [CW-1:0]       hi_count, lo_count;
  qstat_t              hi_stat, lo_stat;
  logic [ID_WIDTH-1:0] hi_rdata, lo_rdata;

  assign adv       = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r  <= op_t'(in_tuser);
      s1_id_r  <= ID_WIDTH'(in_tdata[31:0]);
      s1_cls_r <= in_tdata[39:32];
    end
  end

  assign to_high = (s1_cls_r >= threshold_r);
  assign push_hi = adv && s1_op_r == OP_ENQUEUE && to_high && !hi_stat.full;
  assign push_lo = adv && s1_op_r == OP_ENQUEUE && !to_high && !lo_stat.full;
  assign pop_hi  = adv && s1_op_r == OP_SERVE && !hi_stat.empty;
  assign pop_lo  = adv && s1_op_r == OP_SERVE && hi_stat.empty && !lo_stat.empty;

  always_comb begin
    case (s1_op_r)
      OP_ENQUEUE: begin
        if (to_high) begin
          status_nxt = hi_stat.full ? ST_REFUSED : ST_QUEUED_HIGH;
        end else begin
          status_nxt = lo_stat.full ? ST_REFUSED : ST_QUEUED_LOW;
        end
      end
      OP_SERVE: begin
        if (!hi_stat.empty) begin
          status_nxt = ST_SERVED_HIGH;
        end else if (!lo_stat.empty) begin
          status_nxt = ST_SERVED_LOW;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      default: status_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= 1'b1;
    end else if (out_tready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_status_r <= status_nxt;
    end
  end

  ptq_fifo_ptr #(.DEPTH(QUEUE_DEPTH)) u_hi_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_hi),
    .pop   (pop_hi),
    .head  (hi_head),
    .tail  (hi_tail),
    .count (hi_count),
    .stat  (hi_stat)
  );

  ptq_fifo_ptr #(.DEPTH(QUEUE_DEPTH)) u_lo_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_lo),
    .pop   (pop_lo),
    .head  (lo_head),
    .tail  (lo_tail),
    .count (lo_count),
    .stat  (lo_stat)
  );

  // The read data register only moves on a pop, so it holds while the
  // result transaction is stalled.
  ptq_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (push_hi),
    .waddr (hi_tail),
    .wdata (s1_id_r),
    .re    (pop_hi),
    .raddr (hi_head),
    .rdata (hi_rdata)
  );

  ptq_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (push_lo),
    .waddr (lo_tail),
    .wdata (s1_id_r),
    .re    (pop_lo),
    .raddr (lo_head),
    .rdata (lo_rdata)
  );

  assign out_tvalid = s2_valid_r;
  assign out_tuser  = s2_status_r;

  always_comb begin
    case (s2_status_r)
      ST_SERVED_HIGH: out_tdata = 32'(hi_rdata);
      ST_SERVED_LOW:  out_tdata = 32'(lo_rdata);
      default:        out_tdata = 32'd0;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hi_count <= CW'(QUEUE_DEPTH) && lo_count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    pop_hi |=> hi_count == $past(hi_count) - CW'(1))
    else $error("high queue count did not drop on a serve");

  a_strict_priority: assert property (@(posedge clk) disable iff (!rst_n)
    pop_lo |-> hi_count == '0)
    else $error("low queue served while high queue holds items");
`endif

endmodule : two_class_priority_queue
`default_nettype wire
